// ===== design/pct_pkg.sv =====
// Shared types, sizes and codes of the prefix-code tree decoder.
package pct_pkg;

	// Table sizes
	localparam int MAX_SYMBOLS = 256;
	localparam int MAX_NODES   = 511;
	localparam int STACK_DEPTH = 256;

	// Field widths
	localparam int NODE_IDX_W  = 9;
	localparam int NODE_CNT_W  = 10;
	localparam int STK_ADDR_W  = 8;
	localparam int STK_CNT_W   = 9;
	localparam int LEAF_CNT_W  = 9;
	localparam int SYM_W       = 8;
	localparam int BIT_CNT_W   = 4;

	localparam logic [BIT_CNT_W-1:0] BYTE_BITS = 4'd8;

	// Action codes of an input word
	localparam logic [1:0] ACT_LOAD    = 2'd0;
	localparam logic [1:0] ACT_DECODE  = 2'd1;
	localparam logic [1:0] ACT_RESTART = 2'd2;

	// Node kinds
	localparam logic [1:0] KIND_OPEN  = 2'd0;
	localparam logic [1:0] KIND_LEAF  = 2'd1;
	localparam logic [1:0] KIND_INNER = 2'd2;

	typedef struct packed {
		logic [NODE_IDX_W-1:0] kid0;
		logic [NODE_IDX_W-1:0] kid1;
		logic [1:0]            nkids;
		logic [1:0]            kind;
		logic [SYM_W-1:0]      leafnum;
	} node_t;

	typedef struct packed {
		logic                  en;
		logic [NODE_IDX_W-1:0] addr;
		node_t                 data;
	} node_wr_t;

	typedef struct packed {
		logic                  en;
		logic [NODE_IDX_W-1:0] addr;
	} node_rd_t;

	typedef struct packed {
		logic             push;
		logic             flush;
		logic [SYM_W-1:0] symbol;
		logic             err;
	} emit_req_t;

	localparam node_t NODE_FRESH = '{
		kid0: '0, kid1: '0, nkids: 2'd0, kind: KIND_OPEN, leafnum: '0
	};

endpackage

// ===== design/pct_ifs.sv =====
// Handshake channels of the prefix-code tree decoder: input words and decoded symbols.
interface pct_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic       tree_bit;
	logic [7:0] code_byte;
	logic [3:0] valid_bits;

	modport source (output valid, action, tree_bit, code_byte, valid_bits, input ready);
	modport sink   (input valid, action, tree_bit, code_byte, valid_bits, output ready);
endinterface

interface pct_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] symbol;
	logic       last_of_run;
	logic       tree_error;

	modport source (output valid, symbol, last_of_run, tree_error, input ready);
	modport sink   (input valid, symbol, last_of_run, tree_error, output ready);
endinterface

// ===== design/prefix_code_tree_decoder.sv =====
// Top level of the prefix-code tree decoder: sequencer, node table and symbol staging.
//
// One input word is taken at a time; the block is not ready while a word is in work.
// A restart, an open bit on an empty stack or a load bit that fails its checks is
// handled in the idle state alone; a close bit or an open bit under a parent goes
// through a stack read, a node read and a node write. A decode word walks the first
// min(valid_bits, 8) code bits: each bit needs the current node before it can look
// up the child through the single read port of the node table, and a broken bit or
// a leaf sends the walk back to the root. Symbols leave through a one-word output
// register behind a one-symbol hold stage, so the end-of-run mark can be set on the last
// symbol of a byte; a stalled output holds the walk. The tree needs no clearing after reset.
module prefix_code_tree_decoder (
	input  logic         clk,
	input  logic         arst_n,
	pct_item_if.sink     item,
	pct_result_if.source result
);
	import pct_pkg::*;

	node_wr_t  node_wr;
	node_rd_t  node_rd;
	node_t     node_q;
	emit_req_t emit;
	logic      emit_ready;

	pct_node_ram u_node_ram (
		.clk     (clk),
		.wr      (node_wr),
		.rd      (node_rd),
		.rd_data (node_q)
	);

	pct_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.node_wr    (node_wr),
		.node_rd    (node_rd),
		.node_q     (node_q),
		.emit       (emit),
		.emit_ready (emit_ready)
	);

	pct_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.emit       (emit),
		.emit_ready (emit_ready),
		.result     (result)
	);

endmodule

// ===== design/pct_node_ram.sv =====
// Node table: one write port, one read port with registered read data.
module pct_node_ram (
	input  logic             clk,
	input  pct_pkg::node_wr_t wr,
	input  pct_pkg::node_rd_t rd,
	output pct_pkg::node_t    rd_data
);
	import pct_pkg::*;

	node_t mem [MAX_NODES];

	// Write and read the table; read data holds until the next read
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rd_data <= mem[rd.addr];
		end
	end

endmodule

// ===== design/pct_emit.sv =====
// Symbol staging: holds the newest symbol back until its run end is known, then
// drives the output register.
module pct_emit (
	input  logic               clk,
	input  logic               arst_n,
	input  pct_pkg::emit_req_t emit,
	output logic               emit_ready,
	pct_result_if.source       result
);
	import pct_pkg::*;

	logic             pend_valid_q;
	logic [SYM_W-1:0] pend_sym_q;
	logic             pend_err_q;
	logic             out_valid_q;
	logic [SYM_W-1:0] out_sym_q;
	logic             out_last_q;
	logic             out_err_q;
	logic             slot_free;
	logic             load_out;
	logic             take_new;
	logic             drain;

	assign slot_free  = !out_valid_q || result.ready;
	assign emit_ready = !pend_valid_q || slot_free;
	assign take_new   = emit.push && emit_ready;
	assign drain      = emit.flush && emit_ready;
	assign load_out   = (emit.push || emit.flush) && pend_valid_q && slot_free;

	// Track pending and output occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (take_new) begin
				pend_valid_q <= 1'b1;
			end else if (drain) begin
				pend_valid_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Advance payload from engine to pending to output
	always_ff @(posedge clk) begin
		if (take_new) begin
			pend_sym_q <= emit.symbol;
			pend_err_q <= emit.err;
		end
		if (load_out) begin
			out_sym_q  <= pend_sym_q;
			out_err_q  <= pend_err_q;
			out_last_q <= emit.flush;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.symbol      = out_sym_q;
	assign result.last_of_run = out_last_q;
	assign result.tree_error  = out_err_q;

	a_push_flush_apart: assert property (@(posedge clk) disable iff (!arst_n)
		!(emit.push && emit.flush))
		else $error("symbol push and run flush in the same cycle");

endmodule

// ===== design/pct_engine.sv =====
// Sequencer: builds the code tree from parenthesis bits and walks it bit by bit
// through the shared node-table port.
module pct_engine (
	input  logic               clk,
	input  logic               arst_n,
	pct_item_if.sink           item,
	output pct_pkg::node_wr_t  node_wr,
	output pct_pkg::node_rd_t  node_rd,
	input  pct_pkg::node_t     node_q,
	output pct_pkg::emit_req_t emit,
	input  logic               emit_ready
);
	import pct_pkg::*;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_OP_PAR   = 3'd1;
	localparam logic [2:0] ST_OP_WR    = 3'd2;
	localparam logic [2:0] ST_CL_RD    = 3'd3;
	localparam logic [2:0] ST_CL_WR    = 3'd4;
	localparam logic [2:0] ST_DC_CUR   = 3'd5;
	localparam logic [2:0] ST_DC_CHILD = 3'd6;
	localparam logic [2:0] ST_DC_FLUSH = 3'd7;

	logic [2:0]            state_q, state_d;
	logic [STK_CNT_W-1:0]  stack_top_q, stack_top_d;
	logic [NODE_CNT_W-1:0] nodes_made_q, nodes_made_d;
	logic [LEAF_CNT_W-1:0] leaves_made_q, leaves_made_d;
	logic [NODE_IDX_W-1:0] walk_q, walk_d;
	logic                  err_q, err_d;
	logic [7:0]            byte_q, byte_d;
	logic [BIT_CNT_W-1:0]  nleft_q, nleft_d;
	logic [NODE_IDX_W-1:0] idx_q, idx_d;
	logic [NODE_IDX_W-1:0] newn_q, newn_d;
	logic [NODE_IDX_W-1:0] child_q, child_d;

	logic [NODE_IDX_W-1:0] stack_mem [STACK_DEPTH];
	logic                  stk_wr_en;
	logic [STK_ADDR_W-1:0] stk_wr_addr;
	logic [NODE_IDX_W-1:0] stk_wr_data;
	logic                  stk_rd_en;
	logic [STK_ADDR_W-1:0] stk_rd_addr;
	logic [NODE_IDX_W-1:0] stk_rd_q;

	logic                  accept;
	logic [STK_CNT_W-1:0]  top_m1;
	logic [BIT_CNT_W-1:0]  nbits_sat;
	logic                  cur_bit;
	logic                  walk_bad;
	logic [NODE_IDX_W-1:0] cur_child;

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;
	assign top_m1     = stack_top_q - STK_CNT_W'(1);
	assign nbits_sat  = (item.valid_bits > BYTE_BITS) ? BYTE_BITS : item.valid_bits;
	assign cur_bit    = byte_q[7];
	assign cur_child  = cur_bit ? node_q.kid1 : node_q.kid0;
	assign walk_bad   = ({1'b0, walk_q} >= nodes_made_q) || (node_q.kind != KIND_INNER) ||
	                    (node_q.nkids <= {1'b0, cur_bit});

	// Build stack memory
	always_ff @(posedge clk) begin
		if (stk_wr_en) begin
			stack_mem[stk_wr_addr] <= stk_wr_data;
		end
		if (stk_rd_en) begin
			stk_rd_q <= stack_mem[stk_rd_addr];
		end
	end

	// Sequence loads and tree walks
	always_comb begin
		state_d       = state_q;
		stack_top_d   = stack_top_q;
		nodes_made_d  = nodes_made_q;
		leaves_made_d = leaves_made_q;
		walk_d        = walk_q;
		err_d         = err_q;
		byte_d        = byte_q;
		nleft_d       = nleft_q;
		idx_d         = idx_q;
		newn_d        = newn_q;
		child_d       = child_q;
		node_wr       = '0;
		node_rd       = '0;
		emit          = '0;
		stk_wr_en     = 1'b0;
		stk_wr_addr   = stack_top_q[STK_ADDR_W-1:0];
		stk_wr_data   = nodes_made_q[NODE_IDX_W-1:0];
		stk_rd_en     = 1'b0;
		stk_rd_addr   = top_m1[STK_ADDR_W-1:0];

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (item.action)
						ACT_LOAD: begin
							if (!item.tree_bit) begin
								// open: create node, push it, link it under the parent
								if (nodes_made_q >= NODE_CNT_W'(MAX_NODES) ||
								    stack_top_q >= STK_CNT_W'(STACK_DEPTH)) begin
									err_d = 1'b1;
								end else begin
									node_wr.en   = 1'b1;
									node_wr.addr = nodes_made_q[NODE_IDX_W-1:0];
									node_wr.data = NODE_FRESH;
									stk_wr_en    = 1'b1;
									newn_d       = nodes_made_q[NODE_IDX_W-1:0];
									stack_top_d  = stack_top_q + STK_CNT_W'(1);
									nodes_made_d = nodes_made_q + NODE_CNT_W'(1);
									if (stack_top_q != '0) begin
										stk_rd_en = 1'b1;
										state_d   = ST_OP_PAR;
									end
								end
							end else begin
								// close: pop the top node
								if (stack_top_q == '0) begin
									err_d = 1'b1;
								end else begin
									stack_top_d = top_m1;
									stk_rd_en   = 1'b1;
									state_d     = ST_CL_RD;
								end
							end
						end
						ACT_DECODE: begin
							if (nodes_made_q == '0) begin
								err_d = 1'b1;
							end else if (nbits_sat != '0) begin
								byte_d       = item.code_byte;
								nleft_d      = nbits_sat;
								node_rd.en   = 1'b1;
								node_rd.addr = walk_q;
								state_d      = ST_DC_CUR;
							end
						end
						ACT_RESTART: begin
							walk_d = '0;
						end
						default: begin
						end
					endcase
				end
			end
			ST_OP_PAR: begin
				node_rd.en   = 1'b1;
				node_rd.addr = stk_rd_q;
				idx_d        = stk_rd_q;
				state_d      = ST_OP_WR;
			end
			ST_OP_WR: begin
				node_wr.en   = 1'b1;
				node_wr.addr = idx_q;
				node_wr.data = node_q;
				if (node_q.nkids == 2'd0) begin
					node_wr.data.kid0  = newn_q;
					node_wr.data.nkids = 2'd1;
				end else begin
					node_wr.data.kid1  = newn_q;
					node_wr.data.nkids = 2'd2;
				end
				state_d = ST_IDLE;
			end
			ST_CL_RD: begin
				node_rd.en   = 1'b1;
				node_rd.addr = stk_rd_q;
				idx_d        = stk_rd_q;
				state_d      = ST_CL_WR;
			end
			ST_CL_WR: begin
				node_wr.en   = 1'b1;
				node_wr.addr = idx_q;
				node_wr.data = node_q;
				if (node_q.nkids == 2'd0) begin
					node_wr.data.kind    = KIND_LEAF;
					node_wr.data.leafnum = leaves_made_q[SYM_W-1:0];
					if (leaves_made_q >= LEAF_CNT_W'(MAX_SYMBOLS)) begin
						err_d = 1'b1;
					end else begin
						leaves_made_d = leaves_made_q + LEAF_CNT_W'(1);
					end
				end else begin
					node_wr.data.kind = KIND_INNER;
				end
				state_d = ST_IDLE;
			end
			ST_DC_CUR: begin
				// consume one code bit at the current node
				byte_d  = {byte_q[6:0], 1'b0};
				nleft_d = nleft_q - BIT_CNT_W'(1);
				if (walk_bad) begin
					err_d  = 1'b1;
					walk_d = '0;
					if (nleft_q == BIT_CNT_W'(1)) begin
						state_d = ST_DC_FLUSH;
					end else begin
						node_rd.en   = 1'b1;
						node_rd.addr = '0;
					end
				end else begin
					child_d      = cur_child;
					node_rd.en   = 1'b1;
					node_rd.addr = cur_child;
					state_d      = ST_DC_CHILD;
				end
			end
			ST_DC_CHILD: begin
				if ({1'b0, child_q} < nodes_made_q && node_q.kind == KIND_LEAF) begin
					// leaf: hand over the symbol and restart at the root
					if (emit_ready) begin
						emit.push   = 1'b1;
						emit.symbol = node_q.leafnum;
						emit.err    = err_q;
						walk_d      = '0;
						if (nleft_q == '0) begin
							state_d = ST_DC_FLUSH;
						end else begin
							node_rd.en   = 1'b1;
							node_rd.addr = '0;
							state_d      = ST_DC_CUR;
						end
					end
				end else begin
					// descend: read data already holds the child
					walk_d  = child_q;
					state_d = (nleft_q == '0) ? ST_DC_FLUSH : ST_DC_CUR;
				end
			end
			ST_DC_FLUSH: begin
				emit.flush = 1'b1;
				if (emit_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			stack_top_q   <= '0;
			nodes_made_q  <= '0;
			leaves_made_q <= '0;
			walk_q        <= '0;
			err_q         <= 1'b0;
			nleft_q       <= '0;
		end else begin
			state_q       <= state_d;
			stack_top_q   <= stack_top_d;
			nodes_made_q  <= nodes_made_d;
			leaves_made_q <= leaves_made_d;
			walk_q        <= walk_d;
			err_q         <= err_d;
			nleft_q       <= nleft_d;
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		byte_q  <= byte_d;
		idx_q   <= idx_d;
		newn_q  <= newn_d;
		child_q <= child_d;
	end

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stack_top_q <= STK_CNT_W'(STACK_DEPTH))
		else $error("build stack pointer past its depth");

	a_node_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nodes_made_q <= NODE_CNT_W'(MAX_NODES))
		else $error("node count past table size");

	a_leaf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		leaves_made_q <= LEAF_CNT_W'(MAX_SYMBOLS))
		else $error("leaf count past symbol range");

	a_walk_in_tree: assert property (@(posedge clk) disable iff (!arst_n)
		walk_q == '0 || {1'b0, walk_q} < nodes_made_q)
		else $error("walk pointer outside the built tree");

endmodule

// ===== tb/sv/pct_decode_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard of the prefix-code tree decoder: tracks the tree, predicts symbols, compares them.
module pct_decode_checker
	import pct_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	pct_item_if   item,
	pct_result_if result,
	output int    mismatches,
	output int    symbols_owed
);

	typedef struct {
		logic [SYM_W-1:0] symbol;
		logic             last_of_run;
		logic             tree_error;
	} symbol_t;

	// Own copy of the tree, the build stack and the walk
	node_t                 tree [MAX_NODES];
	logic [NODE_IDX_W-1:0] open_stack [STACK_DEPTH];
	int                    open_depth;
	int                    node_count;
	int                    leaf_count;
	logic [NODE_IDX_W-1:0] walk_at;
	logic                  sticky_err;
	symbol_t               symbols_due [$];
	symbol_t               oldest;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
		mismatches++;
	endtask

	// Grow the tree by one parenthesis bit
	function automatic void take_tree_bit(input logic closing);
		logic [NODE_IDX_W-1:0] parent;
		logic [NODE_IDX_W-1:0] fresh;
		logic [NODE_IDX_W-1:0] done;
		if (!closing) begin
			if (node_count >= MAX_NODES || open_depth >= STACK_DEPTH) begin
				sticky_err = 1'b1;
				return;
			end
			fresh = NODE_IDX_W'(node_count);
			tree[fresh] = NODE_FRESH;
			// hang the new node under the top of the stack; a third child overwrites slot one
			if (open_depth > 0) begin
				parent = open_stack[open_depth - 1];
				if (tree[parent].nkids == 2'd0) begin
					tree[parent].kid0  = fresh;
					tree[parent].nkids = 2'd1;
				end else begin
					tree[parent].kid1  = fresh;
					tree[parent].nkids = 2'd2;
				end
			end
			open_stack[open_depth] = fresh;
			open_depth++;
			node_count++;
		end else begin
			if (open_depth == 0) begin
				sticky_err = 1'b1;
				return;
			end
			open_depth--;
			done = open_stack[open_depth];
			// a childless node becomes the next leaf; past the symbol limit the number wraps
			if (tree[done].nkids == 2'd0) begin
				tree[done].kind    = KIND_LEAF;
				tree[done].leafnum = SYM_W'(leaf_count);
				if (leaf_count >= MAX_SYMBOLS)
					sticky_err = 1'b1;
				else
					leaf_count++;
			end else begin
				tree[done].kind = KIND_INNER;
			end
		end
	endfunction

	// Walk the leading bits of one code byte and queue the symbols it yields
	function automatic void decode_byte(input logic [7:0] code, input logic [3:0] nbits);
		int                    span;
		int                    made;
		logic                  dir;
		logic [NODE_IDX_W-1:0] child;
		symbol_t               run [BYTE_BITS];
		if (node_count == 0) begin
			sticky_err = 1'b1;
			return;
		end
		span = (nbits > BYTE_BITS) ? int'(BYTE_BITS) : int'(nbits);
		made = 0;
		for (int i = 0; i < span; i++) begin
			dir = code[7 - i];
			// a bit at a node that cannot take it breaks the walk back to the root
			if (int'(walk_at) >= node_count || tree[walk_at].kind != KIND_INNER ||
			    tree[walk_at].nkids <= {1'b0, dir}) begin
				sticky_err = 1'b1;
				walk_at    = '0;
				continue;
			end
			child = dir ? tree[walk_at].kid1 : tree[walk_at].kid0;
			if (int'(child) < node_count && tree[child].kind == KIND_LEAF) begin
				run[made] = '{tree[child].leafnum, 1'b0, sticky_err};
				made++;
				walk_at = '0;
			end else begin
				walk_at = child;
			end
		end
		if (made > 0)
			run[made - 1].last_of_run = 1'b1;
		for (int i = 0; i < made; i++)
			symbols_due.insert(symbols_due.size(), run[i]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_depth   = 0;
			node_count   = 0;
			leaf_count   = 0;
			walk_at      = '0;
			sticky_err   = 1'b0;
			mismatches   = 0;
			symbols_due.delete();
			symbols_owed = 0;
		end else begin
			// compare each symbol word with the oldest one owed
			if (result.valid && result.ready) begin
				if (symbols_due.size() == 0) begin
					report_mismatch("symbol with none owed", result.symbol, -1);
				end else begin
					oldest = symbols_due.pop_front();
					if (result.symbol !== oldest.symbol)
						report_mismatch("symbol", result.symbol, oldest.symbol);
					if (result.last_of_run !== oldest.last_of_run)
						report_mismatch("last_of_run", result.last_of_run, oldest.last_of_run);
					if (result.tree_error !== oldest.tree_error)
						report_mismatch("tree_error", result.tree_error, oldest.tree_error);
				end
			end
			// advance the prediction by each accepted input word
			if (item.valid && item.ready) begin
				case (item.action)
					ACT_LOAD: begin
						take_tree_bit(item.tree_bit);
					end
					ACT_DECODE: begin
						decode_byte(item.code_byte, item.valid_bits);
					end
					ACT_RESTART: begin
						walk_at = '0;
					end
					default: begin
					end
				endcase
			end
			symbols_owed = symbols_due.size();
		end
	end

endmodule

// ===== tb/sv/prefix_code_tree_decoder_tb.sv =====
`timescale 1ns / 1ps
// Testbench top of the prefix-code tree decoder: clock, reset, word stimulus, watchdog, verdict.
module prefix_code_tree_decoder_tb;
	import pct_pkg::*;

	localparam logic [1:0] ACT_NONE     = 2'd3;
	localparam logic       OPEN_BIT     = 1'b0;
	localparam logic       CLOSE_BIT    = 1'b1;
	localparam int         IDLE_LIMIT   = 1000;
	localparam int         RANDOM_WORDS = 120;
	localparam int         DRAIN_CYCLES = 40;
	localparam int         SHAPE_CAP    = 40;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	int   mismatches;
	int   symbols_owed;
	int   idle_cycles;
	int   hold_left;
	bit   steady;
	logic shape_bits [$];

	pct_item_if   word_ch ();
	pct_result_if sym_ch ();

	prefix_code_tree_decoder uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (word_ch),
		.result (sym_ch)
	);

	pct_decode_checker scoreboard (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (word_ch),
		.result       (sym_ch),
		.mismatches   (mismatches),
		.symbols_owed (symbols_owed)
	);

	always #5 clk = ~clk;

	// Mostly short pauses, a few long ones, none in a steady stretch
	function automatic int pause_len();
		int r;
		r = $urandom_range(99);
		if (steady || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Mostly one to eight bits, some zero, some above eight
	function automatic logic [3:0] pick_width();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return 4'd0;
		if (r < 20)
			return 4'($urandom_range(9, 15));
		return 4'($urandom_range(1, 8));
	endfunction

	// Append a random subtree: mostly two children, some leaves, unary nodes and third children
	function automatic void grow_subtree(input int depth);
		int r;
		int kids;
		shape_bits.insert(shape_bits.size(), OPEN_BIT);
		r = $urandom_range(99);
		if (depth >= 7 || shape_bits.size() > SHAPE_CAP || r < 35)
			kids = 0;
		else if (r < 43)
			kids = 1;
		else if (r < 50)
			kids = 3;
		else
			kids = 2;
		for (int k = 0; k < kids; k++)
			grow_subtree(depth + 1);
		shape_bits.insert(shape_bits.size(), CLOSE_BIT);
	endfunction

	// Offer one word after a random pause and hold it until taken
	task automatic send_word(input logic [1:0] act, input logic bit_in,
	                         input logic [7:0] code_in, input logic [3:0] nbits);
		int gap;
		gap = pause_len();
		if (gap > 0) begin
			word_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		word_ch.valid      <= 1'b1;
		word_ch.action     <= act;
		word_ch.tree_bit   <= bit_in;
		word_ch.code_byte  <= code_in;
		word_ch.valid_bits <= nbits;
		do @(posedge clk); while (!(word_ch.valid && word_ch.ready));
	endtask

	task automatic load_bit(input logic paren);
		send_word(ACT_LOAD, paren, 8'($urandom), 4'($urandom));
	endtask

	task automatic decode_word(input logic [7:0] code_in, input logic [3:0] nbits);
		send_word(ACT_DECODE, 1'($urandom), code_in, nbits);
	endtask

	task automatic restart_walk();
		send_word(ACT_RESTART, 1'($urandom), 8'($urandom), 4'($urandom));
	endtask

	// Stall the symbol side at random
	initial begin
		sym_ch.ready <= 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				sym_ch.ready <= 1'b0;
			end else if (!steady && $urandom_range(4) == 0) begin
				hold_left = pause_len();
				sym_ch.ready <= 1'b0;
			end else begin
				sym_ch.ready <= 1'b1;
			end
		end
	end

	// End the run once nothing moves on either channel for too long
	always @(posedge clk) begin
		if (!arst_n || (word_ch.valid && word_ch.ready) || (sym_ch.valid && sym_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
			$display("FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int r;
		steady = 1'b0;
		word_ch.valid      <= 1'b0;
		word_ch.action     <= ACT_LOAD;
		word_ch.tree_bit   <= OPEN_BIT;
		word_ch.code_byte  <= 8'h00;
		word_ch.valid_bits <= 4'd0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Decode into an empty tree; the error flag stays set from here on
		decode_word(8'hA5, 4'd8);
		send_word(ACT_NONE, 1'b1, 8'hFF, 4'hF);
		restart_walk();
		// close with nothing open
		load_bit(CLOSE_BIT);

		// Load the code tree: a leaf on the zero side of the root, a random subtree on the one side
		shape_bits.insert(shape_bits.size(), OPEN_BIT);
		shape_bits.insert(shape_bits.size(), OPEN_BIT);
		shape_bits.insert(shape_bits.size(), CLOSE_BIT);
		grow_subtree(1);
		shape_bits.insert(shape_bits.size(), CLOSE_BIT);
		foreach (shape_bits[i])
			load_bit(shape_bits[i]);

		// Eight symbols from one byte, the one-side spine, saturated and empty widths
		decode_word(8'h00, 4'd8);
		decode_word(8'hFF, 4'd8);
		decode_word(8'hFF, 4'hF);
		decode_word(8'h3C, 4'd0);
		// carry a partial walk into the next byte
		decode_word(8'h80, 4'd1);
		decode_word(8'h40, 4'd8);
		// drop a partial walk
		decode_word(8'hC0, 4'd2);
		restart_walk();
		decode_word(8'h00, 4'd1);
		decode_word(8'h5A, 4'd9);
		send_word(ACT_NONE, 1'b0, 8'h00, 4'd0);

		// Random mix, mostly decodes over the loaded tree
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 30 == 0)
				steady = ($urandom_range(3) == 0);
			r = $urandom_range(99);
			if (r < 70)
				decode_word(8'($urandom), pick_width());
			else if (r < 80)
				restart_walk();
			else if (r < 85)
				send_word(ACT_NONE, 1'($urandom), 8'($urandom), 4'($urandom));
			else
				load_bit(1'($urandom));
		end
		steady = 1'b0;

		// Close a few more nodes, past an empty stack when little is open
		repeat (3) load_bit(CLOSE_BIT);

		// The walked tree is untouched by detached nodes
		repeat (10) decode_word(8'($urandom), pick_width());
		word_ch.valid <= 1'b0;

		// Drain the owed symbols, then watch for strays
		do @(negedge clk); while (symbols_owed != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0 && symbols_owed == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/pct_pkg.sv
design/pct_ifs.sv
design/pct_node_ram.sv
design/pct_emit.sv
design/pct_engine.sv
design/prefix_code_tree_decoder.sv
tb/sv/pct_decode_checker.sv
tb/sv/prefix_code_tree_decoder_tb.sv
